[rtl/rsas_pkg.sv]
// shared constants and beat types for the rotated sorted array search
package rsas_pkg;

  localparam int unsigned Depth  = 1024;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned CountW = $clog2(Depth + 1);
  localparam int unsigned DataW  = 32;
  localparam int unsigned PosW   = 10;

  localparam logic KindLoad   = 1'b0;
  localparam logic KindSearch = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic signed [DataW-1:0] value;
    logic                    start_req;
  } in_t;

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] position;
    logic            truncated;
  } out_t;

endpackage

[rtl/rotated_sorted_array_search.sv]
// Search in a rotated ascending array of distinct signed 32-bit elements. A load beat
// (kind 0) appends one element, start_req beginning a new array; loads past the
// 1024-entry store are dropped and flagged as truncated. A search beat (kind 1) runs a
// binary search that reads one element of the single-port store per probe: each probe
// issues an address, then compares the registered read data. One search is in flight at
// a time; its result waits in an output register, and new beats are taken once the
// search has handed its result over.
module rotated_sorted_array_search (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rsas_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rsas_pkg::out_t out_data_o
);

  logic                       idle;
  logic                       res_valid;
  rsas_pkg::out_t             res;
  logic                       ram_we;
  logic [rsas_pkg::AddrW-1:0] ram_addr;
  logic [rsas_pkg::DataW-1:0] ram_wdata;
  logic [rsas_pkg::DataW-1:0] ram_rdata;

  logic           out_valid_q;
  rsas_pkg::out_t out_q;
  logic           out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !idle;

  rsas_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .idle_o      (idle),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata)
  );

  rsas_ram #(
    .Width (rsas_pkg::DataW),
    .Depth (rsas_pkg::Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // result beat holding register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/rsas_ram.sv]
// generic single-port ram with registered read
module rsas_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/rsas_ctrl.sv]
// array bookkeeping and the binary search sequencer around the element ram
module rsas_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  rsas_pkg::in_t              in_data_i,
  output logic                       idle_o,
  input  logic                       out_free_i,
  output logic                       res_valid_o,
  output rsas_pkg::out_t             res_o,
  output logic                       ram_we_o,
  output logic [rsas_pkg::AddrW-1:0] ram_addr_o,
  output logic [rsas_pkg::DataW-1:0] ram_wdata_o,
  input  logic [rsas_pkg::DataW-1:0] ram_rdata_i
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_CMP   = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [rsas_pkg::CountW-1:0] count_q, count_d;
  logic                        ovf_q, ovf_d;
  logic signed [rsas_pkg::DataW-1:0] first_q, first_d;
  logic signed [rsas_pkg::DataW-1:0] last_q, last_d;
  logic signed [rsas_pkg::DataW-1:0] target_q, target_d;
  // search window is [left, hi)
  logic [rsas_pkg::CountW-1:0] left_q, left_d;
  logic [rsas_pkg::CountW-1:0] hi_q, hi_d;
  logic [rsas_pkg::CountW-1:0] mid_q, mid_d;
  logic                        found_q, found_d;

  logic                              accept;
  logic [rsas_pkg::CountW-1:0]       count_eff;
  logic [rsas_pkg::CountW:0]         mid_sum;
  logic signed [rsas_pkg::DataW-1:0] probe;
  logic [rsas_pkg::CountW-1:0]       left_n, hi_n;

  assign accept  = in_valid_i && (state_q == S_IDLE);
  assign idle_o  = (state_q == S_IDLE);
  assign probe   = signed'(ram_rdata_i);
  assign mid_sum = {1'b0, left_q} + {1'b0, hi_q} - {{rsas_pkg::CountW{1'b0}}, 1'b1};
  assign count_eff = in_data_i.start_req ? '0 : count_q;

  // narrow the window around the probe
  always_comb begin
    left_n = left_q;
    hi_n   = hi_q;
    if (first_q <= probe) begin
      if (first_q <= target_q && target_q < probe) begin
        hi_n = mid_q;
      end else begin
        left_n = mid_q + 1'b1;
      end
    end else begin
      if (probe < target_q && target_q <= last_q) begin
        left_n = mid_q + 1'b1;
      end else begin
        hi_n = mid_q;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    first_d     = first_q;
    last_d      = last_q;
    target_d    = target_q;
    left_d      = left_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    found_d     = found_q;
    ram_we_o    = 1'b0;
    ram_addr_o  = mid_q[rsas_pkg::AddrW-1:0];
    ram_wdata_o = in_data_i.value;
    res_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        ram_addr_o = count_eff[rsas_pkg::AddrW-1:0];
        if (accept) begin
          if (in_data_i.kind == rsas_pkg::KindLoad) begin
            if (in_data_i.start_req) begin
              ovf_d = 1'b0;
            end
            if (count_eff < rsas_pkg::CountW'(rsas_pkg::Depth)) begin
              ram_we_o = 1'b1;
              if (count_eff == '0) begin
                first_d = in_data_i.value;
              end
              last_d  = in_data_i.value;
              count_d = count_eff + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end else begin
            target_d = in_data_i.value;
            left_d   = '0;
            hi_d     = count_q;
            mid_d    = '0;
            found_d  = 1'b0;
            state_d  = (count_q == '0) ? S_DONE : S_ISSUE;
          end
        end
      end
      S_ISSUE: begin
        mid_d      = mid_sum[rsas_pkg::CountW:1];
        ram_addr_o = mid_d[rsas_pkg::AddrW-1:0];
        state_d    = S_CMP;
      end
      S_CMP: begin
        if (probe == target_q) begin
          found_d = 1'b1;
          state_d = S_DONE;
        end else begin
          left_d  = left_n;
          hi_d    = hi_n;
          state_d = (left_n < hi_n) ? S_ISSUE : S_DONE;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o.found     = found_q;
  assign res_o.position  = found_q ? rsas_pkg::PosW'(mid_q) : '0;
  assign res_o.truncated = ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ovf_q   <= 1'b0;
      first_q <= '0;
      last_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      first_q <= first_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    target_q <= target_d;
    left_q   <= left_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    found_q  <= found_d;
  end

endmodule

[rtl/rsas_checker.sv]
// port-level checks for the rotated sorted array search
module rsas_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input rsas_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input rsas_pkg::out_t out_data_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // a waiting result beat stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  // only one search in flight
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.kind == rsas_pkg::KindSearch) |=> in_stall_o)
    else $error("beat taken right after a search");

  // a load never yields a result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.kind == rsas_pkg::KindLoad) && !out_valid_o |=> !out_valid_o)
    else $error("result after a load");

  // position is zero when nothing was found
  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |-> out_data_o.position == '0)
    else $error("nonzero position on a miss");

endmodule

bind rotated_sorted_array_search rsas_checker u_rsas_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

[tb/sv/tb.sv]
// testbench for the rotated sorted array search block
`timescale 1ns / 1ps

module tb;

  localparam int StoreDepth  = rsas_pkg::Depth;
  localparam int IntMin      = 32'sh8000_0000;
  localparam int IntMax      = 32'sh7fff_ffff;
  localparam int RandomBeats = 100;
  localparam int HoldCycles  = 300;
  localparam int CycleLimit  = 1_000_000;
  localparam int SettleCycles = 40;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  rsas_pkg::in_t  in_data_i   = '0;
  logic           out_stall_i = 1'b0;
  logic           in_stall_o;
  logic           out_valid_o;
  rsas_pkg::out_t out_data_o;

  rotated_sorted_array_search uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // array state as the block should hold it
  int   elem_store [StoreDepth];
  int   elem_count  = 0;
  int   first_elem  = 0;
  int   last_elem   = 0;
  logic trunc_seen  = 1'b0;

  rsas_pkg::out_t pending_results [$];
  int   n_errors    = 0;
  int   beats_sent  = 0;
  int   cycle_count = 0;

  bit   tx_idle_on   = 1'b0;
  bit   rx_idle_on   = 1'b0;
  int   hold_request = 0;
  int   rx_len;
  int   rx_roll;
  rsas_pkg::out_t seen_result;
  rsas_pkg::out_t want_result;

  function automatic void search_array(input int target, output logic hit,
                                       output logic [rsas_pkg::PosW-1:0] where);
    int lo;
    int hi;
    int mid;
    int probe;
    lo    = 0;
    hi    = elem_count - 1;
    hit   = 1'b0;
    where = '0;
    while (lo <= hi) begin
      mid   = lo + (hi - lo) / 2;
      probe = elem_store[mid];
      if (probe == target) begin
        hit   = 1'b1;
        where = mid[rsas_pkg::PosW-1:0];
        return;
      end
      // pick the sorted half, then keep the side that can hold the target
      if (first_elem <= probe) begin
        if (first_elem <= target && target < probe) hi = mid - 1;
        else lo = mid + 1;
      end else begin
        if (probe < target && target <= last_elem) lo = mid + 1;
        else hi = mid - 1;
      end
    end
  endfunction

  function automatic void track_beat(input rsas_pkg::in_t beat);
    rsas_pkg::out_t res;
    logic hit;
    logic [rsas_pkg::PosW-1:0] where;
    if (beat.kind == rsas_pkg::KindLoad) begin
      if (beat.start_req) begin
        elem_count = 0;
        trunc_seen = 1'b0;
      end
      if (elem_count >= StoreDepth) begin
        trunc_seen = 1'b1;
      end else begin
        elem_store[elem_count] = beat.value;
        if (elem_count == 0) first_elem = beat.value;
        last_elem  = beat.value;
        elem_count = elem_count + 1;
      end
    end else begin
      search_array(beat.value, hit, where);
      res.found     = hit;
      res.position  = where;
      res.truncated = trunc_seen;
      pending_results.push_back(res);
    end
  endfunction

  // called at a rising edge, returns at the edge where the beat is taken
  task automatic send_beat(input logic kind, input int value, input logic start);
    rsas_pkg::in_t beat;
    int  gap;
    int  roll;
    gap = 0;
    if (tx_idle_on) begin
      roll = $urandom_range(0, 99);
      if (roll >= 92) gap = $urandom_range(6, 40);
      else if (roll >= 65) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    beat.kind      = kind;
    beat.value     = value;
    beat.start_req = start;
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(negedge clk_i);
    while (in_stall_o !== 1'b0) @(negedge clk_i);
    @(posedge clk_i);
    track_beat(beat);
    beats_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic test_empty_search();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_beat(rsas_pkg::KindSearch, 0, 1'b0);
    send_beat(rsas_pkg::KindSearch, IntMin, 1'b1);
    wait_idle();
  endtask

  task automatic test_rotated_extremes();
    int vals[$];
    vals = '{40, 50, IntMax, IntMin, -7, 0, 3};
    foreach (vals[i]) send_beat(rsas_pkg::KindLoad, vals[i], i == 0);
    send_beat(rsas_pkg::KindSearch, 40, 1'b0);
    send_beat(rsas_pkg::KindSearch, 3, 1'b0);
    send_beat(rsas_pkg::KindSearch, IntMax, 1'b0);
    send_beat(rsas_pkg::KindSearch, IntMin, 1'b0);
    send_beat(rsas_pkg::KindSearch, -7, 1'b0);
    send_beat(rsas_pkg::KindSearch, 1, 1'b0);
    send_beat(rsas_pkg::KindSearch, 60, 1'b0);
    send_beat(rsas_pkg::KindSearch, IntMin + 1, 1'b0);
    // start flag on a search leaves the array alone
    send_beat(rsas_pkg::KindSearch, 50, 1'b1);
    send_beat(rsas_pkg::KindSearch, 0, 1'b0);
    wait_idle();
  endtask

  task automatic test_odd_arrays();
    int vals[$];
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_beat(rsas_pkg::KindLoad, 5, 1'b1);
    send_beat(rsas_pkg::KindSearch, 5, 1'b0);
    send_beat(rsas_pkg::KindSearch, 4, 1'b0);
    // duplicates and no order: same probe walk, whatever it lands on
    vals = '{3, 3, 1, 9, 2};
    foreach (vals[i]) send_beat(rsas_pkg::KindLoad, vals[i], i == 0);
    send_beat(rsas_pkg::KindSearch, 3, 1'b0);
    send_beat(rsas_pkg::KindSearch, 2, 1'b0);
    send_beat(rsas_pkg::KindSearch, 9, 1'b0);
    wait_idle();
  endtask

  task automatic test_full_store();
    int     asc[$];
    int     arr[$];
    int     k;
    longint v;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (int i = 0; i < StoreDepth; i++) begin
      v = longint'(IntMin) + longint'(i) * 4_000_000 + $urandom_range(0, 3_000_000);
      asc.push_back(int'(v));
    end
    k = $urandom_range(1, StoreDepth - 1);
    for (int i = 0; i < StoreDepth; i++) arr.push_back(asc[(i + k) % StoreDepth]);
    foreach (arr[i]) send_beat(rsas_pkg::KindLoad, arr[i], i == 0);
    send_beat(rsas_pkg::KindSearch, arr[0], 1'b0);
    send_beat(rsas_pkg::KindSearch, arr[StoreDepth - 1], 1'b0);
    send_beat(rsas_pkg::KindSearch, arr[StoreDepth - k], 1'b0);
    send_beat(rsas_pkg::KindSearch, arr[$urandom_range(0, StoreDepth - 1)], 1'b0);
    send_beat(rsas_pkg::KindSearch, arr[5] + 1, 1'b0);
    // store is full, these loads get dropped
    repeat (3) send_beat(rsas_pkg::KindLoad, int'($urandom), 1'b0);
    send_beat(rsas_pkg::KindSearch, arr[StoreDepth / 2], 1'b0);
    send_beat(rsas_pkg::KindSearch, IntMax, 1'b0);
    send_beat(rsas_pkg::KindSearch, IntMin, 1'b0);
    send_beat(rsas_pkg::KindSearch, arr[1], 1'b0);
    // fresh array clears the overflow flag
    send_beat(rsas_pkg::KindLoad, 17, 1'b1);
    send_beat(rsas_pkg::KindSearch, 17, 1'b0);
    wait_idle();
  endtask

  task automatic test_output_hold_off();
    int vals[$];
    vals = '{0, 50, 100, -100, -50};
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    foreach (vals[i]) send_beat(rsas_pkg::KindLoad, vals[i], i == 0);
    hold_request = HoldCycles;
    for (int i = 0; i < 30; i++) begin
      if (i % 3 == 2) begin
        send_beat(rsas_pkg::KindSearch, int'($urandom_range(0, 300)) - 150, 1'b0);
      end else begin
        send_beat(rsas_pkg::KindSearch, vals[$urandom_range(0, vals.size() - 1)], 1'b0);
      end
    end
    wait_idle();
  endtask

  task automatic test_random_arrays();
    int asc[$];
    int arr[$];
    int len;
    int shape;
    int k;
    int n_search;
    int roll;
    int target;
    int stop_at;
    bit narrow;
    stop_at = beats_sent + RandomBeats;
    while (beats_sent < stop_at) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      shape = $urandom_range(0, 99);
      len   = (shape < 2) ? $urandom_range(25, 60) : $urandom_range(1, 24);
      asc.delete();
      arr.delete();
      if (shape < 88) begin
        narrow = ($urandom_range(0, 1) != 0);
        for (int i = 0; i < len; i++) begin
          if (narrow) asc.push_back(int'($urandom_range(0, 4 * len)) - 2 * len);
          else asc.push_back(int'($urandom));
        end
        asc.sort();
        foreach (asc[i]) begin
          if (i == 0 || asc[i] != asc[i - 1]) arr.push_back(asc[i]);
        end
        k = $urandom_range(0, arr.size() - 1);
        asc = arr;
        foreach (asc[i]) arr[i] = asc[(i + k) % asc.size()];
      end else begin
        for (int i = 0; i < len; i++) arr.push_back(int'($urandom_range(0, 7)));
      end
      foreach (arr[i]) begin
        send_beat(rsas_pkg::KindLoad, arr[i], i == 0);
        // now and then probe a half-loaded array
        if ($urandom_range(0, 99) < 3)
          send_beat(rsas_pkg::KindSearch, arr[$urandom_range(0, i)],
                    $urandom_range(0, 1) != 0);
      end
      // appending without a start breaks the order
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) send_beat(rsas_pkg::KindLoad, int'($urandom), 1'b0);
      end
      n_search = $urandom_range(4, 16);
      repeat (n_search) begin
        roll = $urandom_range(0, 99);
        if (roll < 55) target = arr[$urandom_range(0, arr.size() - 1)];
        else if (roll < 75) target = arr[$urandom_range(0, arr.size() - 1)]
                                     + (($urandom_range(0, 1) != 0) ? 1 : -1);
        else if (roll < 80) target = IntMin;
        else if (roll < 85) target = IntMax;
        else target = int'($urandom);
        send_beat(rsas_pkg::KindSearch, target, $urandom_range(0, 7) == 0);
      end
      if ($urandom_range(0, 4) == 0) wait_idle();
    end
    wait_idle();
  endtask

  // receiver side stall pattern, with a long hold-off on request
  always begin
    @(posedge clk_i);
    if (hold_request > 0) begin
      rx_len       = hold_request;
      hold_request = 0;
      out_stall_i <= 1'b1;
      repeat (rx_len) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end else if (rx_idle_on) begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 70) begin
        out_stall_i <= 1'b0;
      end else begin
        rx_len = (rx_roll < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        out_stall_i <= 1'b1;
        repeat (rx_len) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // a result beat is taken at the next rising edge when valid and not stalled here
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      seen_result = out_data_o;
      if (pending_results.size() == 0) begin
        $error("result beat with no search pending: %p", seen_result);
        n_errors++;
      end else begin
        want_result = pending_results.pop_front();
        if (seen_result.found !== want_result.found) begin
          $error("found: expected %0d, got %0d", want_result.found, seen_result.found);
          n_errors++;
        end
        if (seen_result.position !== want_result.position) begin
          $error("position: expected %0d, got %0d", want_result.position,
                 seen_result.position);
          n_errors++;
        end
        if (seen_result.truncated !== want_result.truncated) begin
          $error("truncated: expected %0d, got %0d", want_result.truncated,
                 seen_result.truncated);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_search();
    test_rotated_extremes();
    test_odd_arrays();
    test_full_store();
    test_output_hold_off();
    test_random_arrays();
    repeat (SettleCycles) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[rotated_sorted_array_search.f]
rtl/rsas_pkg.sv
rtl/rsas_ram.sv
rtl/rsas_ctrl.sv
rtl/rotated_sorted_array_search.sv
rtl/rsas_checker.sv
tb/sv/tb.sv
